// ----- hw/rtl/grm_pkg.sv -----
// ----------------------------------------------------------------------------
// grm_pkg
// Shared widths, register indexes and limits for the gear ratio matcher.
// ----------------------------------------------------------------------------
package grm_pkg;

  localparam int SPEED_W    = 16;
  localparam int RPM_W      = 15;
  localparam int TIME_W     = 64;
  localparam int GEAR_W     = 4;
  localparam int RATIO_W    = 16;
  localparam int PROD_W     = 32;
  localparam int ERR_W      = 16;
  localparam int AGREE_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int MAX_GEARS  = 8;
  localparam int LIVE_SHIFT = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATIO_LO  = 3'd0,
    CFG_RATIO_HI  = 3'd1,
    CFG_MIN_SPEED = 3'd2,
    CFG_MIN_RPM   = 3'd3,
    CFG_THRESHOLD = 3'd4,
    CFG_HYST      = 3'd5
  } cfg_idx_t;

  localparam logic [CFG_DATA_W-1:0] RST_RATIO     = '0;
  localparam logic [SPEED_W-1:0]    RST_MIN_SPEED = 16'd320;
  localparam logic [RPM_W-1:0]      RST_MIN_RPM   = 15'd800;
  localparam logic [ERR_W-1:0]      RST_THRESHOLD = 16'd6554;
  localparam logic [AGREE_W-1:0]    RST_HYST      = 8'd3;
  localparam logic [AGREE_W-1:0]    AGREE_MAX     = '1;

endpackage

// ----- hw/rtl/grm_if.sv -----
// ----------------------------------------------------------------------------
// grm_if
// Valid/ready channels for sample requests and gear estimate results.
// ----------------------------------------------------------------------------
interface grm_in_if import grm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_raw;
  logic [RPM_W-1:0]   engine_rpm;
  logic [TIME_W-1:0]  now_us;

  modport source (output valid, output speed_raw, output engine_rpm, output now_us,
                  input ready);
  modport sink   (input valid, input speed_raw, input engine_rpm, input now_us,
                  output ready);
endinterface

interface grm_out_if import grm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GEAR_W-1:0] gear_out;
  logic              gear_ok;
  logic [TIME_W-1:0] change_time_us;

  modport source (output valid, output gear_out, output gear_ok, output change_time_us,
                  input ready);
  modport sink   (input valid, input gear_out, input gear_ok, input change_time_us,
                  output ready);
endinterface

// ----- hw/rtl/grm_mul.sv -----
// ----------------------------------------------------------------------------
// grm_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module grm_mul import grm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [RATIO_W-1:0] mcand,
  input  logic [SPEED_W-1:0] mplier,
  output logic               done,
  output logic [PROD_W-1:0]  prod
);

  localparam int CNT_W = $clog2(SPEED_W);

  logic               busy_r,   busy_nxt;
  logic               done_r,   done_nxt;
  logic [CNT_W-1:0]   cnt_r,    cnt_nxt;
  logic [PROD_W-1:0]  acc_r,    acc_nxt;
  logic [PROD_W-1:0]  mcand_r,  mcand_nxt;
  logic [SPEED_W-1:0] mplier_r, mplier_nxt;

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    if (start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = '0;
      acc_nxt    = '0;
      mcand_nxt  = PROD_W'(mcand);
      mplier_nxt = mplier;
    end else if (busy_r) begin
      acc_nxt    = acc_r + (mplier_r[0] ? mcand_r : '0);
      mcand_nxt  = {mcand_r[PROD_W-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[SPEED_W-1:1]};
      cnt_nxt    = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(SPEED_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ----- hw/rtl/grm_div.sv -----
// ----------------------------------------------------------------------------
// grm_div
// Restoring divider producing a Q0.16 fraction num/den, one bit per cycle.
// Requires num < den.
// ----------------------------------------------------------------------------
module grm_div import grm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] num,
  input  logic [PROD_W-1:0] den,
  output logic              done,
  output logic [ERR_W-1:0]  quo
);

  localparam int CNT_W = $clog2(ERR_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic [PROD_W-1:0] rem_r,  rem_nxt;
  logic [PROD_W-1:0] den_r,  den_nxt;
  logic [ERR_W-1:0]  quo_r,  quo_nxt;
  logic [PROD_W:0]   shifted;
  logic              fits;

  always_comb begin
    shifted  = {rem_r, 1'b0};
    fits     = shifted >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = num;
      den_nxt  = den;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? PROD_W'(shifted - {1'b0, den_r}) : shifted[PROD_W-1:0];
      quo_nxt = {quo_r[ERR_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ERR_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- hw/rtl/gear_ratio_matcher_hysteresis.sv -----
// ----------------------------------------------------------------------------
// gear_ratio_matcher_hysteresis
// Gear estimator: matches live rpm/speed against per-gear Q8.8 ratios and
// adopts a gear after a configurable run of equal winners.
// ----------------------------------------------------------------------------
// One sample is handled at a time. A sample below the speed or rpm floor goes
// straight to the output state. Otherwise each calibrated gear (nonzero ratio,
// up to NUM_GEARS) runs the bit-serial multiplier for ratio*speed and the
// bit-serial divider for the relative error; a gear whose error is at least
// 1.0 skips the divider, and an uncalibrated gear is skipped. A new sample is
// taken while the last result still waits in the output register.
// ----------------------------------------------------------------------------
module gear_ratio_matcher_hysteresis import grm_pkg::*; #(
  parameter int NUM_GEARS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  grm_in_if.sink                in_ch,
  grm_out_if.source             out_ch
);

  localparam logic [GEAR_W-1:0] LastGear = GEAR_W'(NUM_GEARS);

  typedef enum logic [2:0] {
    S_IDLE, S_SEL, S_MUL, S_DIFF, S_CHK, S_DIV, S_DECIDE, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [CFG_DATA_W-1:0] ratio_lo_r, ratio_hi_r;
  logic [SPEED_W-1:0]    min_speed_r;
  logic [RPM_W-1:0]      min_rpm_r;
  logic [ERR_W-1:0]      threshold_r;
  logic [AGREE_W-1:0]    hyst_r;

  // estimator state
  logic [GEAR_W-1:0]  cur_gear_r;
  logic               cur_valid_r;
  logic [TIME_W-1:0]  stamp_r;
  logic [AGREE_W-1:0] agree_r;
  logic [GEAR_W-1:0]  last_win_r;

  // per-sample work
  logic [SPEED_W-1:0] speed_r;
  logic [RPM_W-1:0]   rpm_r;
  logic [TIME_W-1:0]  now_r;
  logic [GEAR_W-1:0]  gear_r;
  logic [GEAR_W-1:0]  best_r;
  logic [ERR_W-1:0]   best_err_r;
  logic [PROD_W-1:0]  ref_r;
  logic [PROD_W-1:0]  diff_r, diff_nxt;
  logic               mul_start_r, div_start_r;

  // result register
  logic               out_valid_r;
  logic [GEAR_W-1:0]  out_gear_r;
  logic               out_ok_r;
  logic [TIME_W-1:0]  out_time_r;

  logic [MAX_GEARS-1:0][RATIO_W-1:0] ratios;
  logic [GEAR_W-1:0]  gidx;
  logic [RATIO_W-1:0] ratio_sel;
  logic               mul_done, div_done;
  logic [PROD_W-1:0]  mul_prod;
  logic [ERR_W-1:0]   div_quo;
  logic [PROD_W-1:0]  live;
  logic               below_min;
  logic               in_fire;
  logic               same_win;
  logic [AGREE_W-1:0] agree_nxt;
  logic [GEAR_W-1:0]  last_win_nxt;

  assign ratios    = {ratio_hi_r, ratio_lo_r};
  assign gidx      = gear_r - 1'b1;
  assign ratio_sel = ratios[gidx[2:0]];
  assign live      = PROD_W'({rpm_r, LIVE_SHIFT'(0)});
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign below_min = (in_ch.speed_raw == '0) || (in_ch.speed_raw < min_speed_r) ||
                     (in_ch.engine_rpm < min_rpm_r);

  always_comb begin
    diff_nxt = (live >= ref_r) ? (live - ref_r) : (ref_r - live);
  end

  always_comb begin
    same_win = (best_r != '0) && (best_r == last_win_r);
    if (same_win) begin
      agree_nxt    = (agree_r == AGREE_MAX) ? agree_r : agree_r + 1'b1;
      last_win_nxt = last_win_r;
    end else begin
      agree_nxt    = AGREE_W'(1);
      last_win_nxt = best_r;
    end
  end

  grm_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start_r),
    .mcand  (ratio_sel),
    .mplier (speed_r),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  grm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (diff_r),
    .den   (ref_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_lo_r  <= RST_RATIO;
      ratio_hi_r  <= RST_RATIO;
      min_speed_r <= RST_MIN_SPEED;
      min_rpm_r   <= RST_MIN_RPM;
      threshold_r <= RST_THRESHOLD;
      hyst_r      <= RST_HYST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RATIO_LO:  ratio_lo_r  <= cfg_data;
        CFG_RATIO_HI:  ratio_hi_r  <= cfg_data;
        CFG_MIN_SPEED: min_speed_r <= cfg_data[SPEED_W-1:0];
        CFG_MIN_RPM:   min_rpm_r   <= cfg_data[RPM_W-1:0];
        CFG_THRESHOLD: threshold_r <= cfg_data[ERR_W-1:0];
        CFG_HYST:      hyst_r      <= cfg_data[AGREE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_gear_r  <= '0;
      cur_valid_r <= 1'b0;
      stamp_r     <= '0;
      agree_r     <= '0;
      last_win_r  <= '0;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      if (out_valid_r && out_ch.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            speed_r    <= in_ch.speed_raw;
            rpm_r      <= in_ch.engine_rpm;
            now_r      <= in_ch.now_us;
            gear_r     <= GEAR_W'(1);
            best_r     <= '0;
            best_err_r <= threshold_r;
            if (below_min) begin
              if (cur_gear_r != '0) begin
                cur_gear_r  <= '0;
                cur_valid_r <= 1'b0;
                stamp_r     <= in_ch.now_us;
                agree_r     <= '0;
                last_win_r  <= '0;
              end
              state_r <= S_OUT;
            end else begin
              state_r <= S_SEL;
            end
          end
        end
        S_SEL: begin
          if (gear_r > LastGear) begin
            state_r <= S_DECIDE;
          end else if (ratio_sel == '0) begin
            gear_r <= gear_r + 1'b1;
          end else begin
            mul_start_r <= 1'b1;
            state_r     <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            ref_r   <= mul_prod;
            state_r <= S_DIFF;
          end
        end
        S_DIFF: begin
          diff_r  <= diff_nxt;
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (diff_r >= ref_r) begin
            gear_r  <= gear_r + 1'b1;
            state_r <= S_SEL;
          end else begin
            div_start_r <= 1'b1;
            state_r     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_quo < best_err_r) begin
              best_err_r <= div_quo;
              best_r     <= gear_r;
            end
            gear_r  <= gear_r + 1'b1;
            state_r <= S_SEL;
          end
        end
        S_DECIDE: begin
          agree_r    <= agree_nxt;
          last_win_r <= last_win_nxt;
          if (best_r != '0 && agree_nxt >= hyst_r) begin
            if (cur_gear_r != best_r) begin
              cur_gear_r  <= best_r;
              cur_valid_r <= 1'b1;
              stamp_r     <= now_r;
            end
          end else if (best_r == '0 && cur_gear_r != '0) begin
            cur_gear_r  <= '0;
            cur_valid_r <= 1'b0;
            stamp_r     <= now_r;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_gear_r  <= cur_gear_r;
            out_ok_r    <= cur_valid_r;
            out_time_r  <= stamp_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.gear_out       = out_gear_r;
  assign out_ch.gear_ok        = out_ok_r;
  assign out_ch.change_time_us = out_time_r;

  a_ok_matches_gear: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.gear_ok == (out_ch.gear_out != '0)))
    else $error("gear_ok disagrees with gear_out");

  a_gear_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_gear_r <= LastGear)
    else $error("current gear beyond configured gear count");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_MUL))
    else $error("multiplier finished outside its wait state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside its wait state");

  a_div_start_fits: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> (diff_r < ref_r))
    else $error("division started with quotient overflow");

endmodule

// ----- test/tb_gear_ratio_matcher_hysteresis.sv -----
// ----------------------------------------------------------------------------
// tb_gear_ratio_matcher_hysteresis
// Self-checking bench for the gear estimator. A directed script covers floors,
// standstill, hysteresis, threshold and ratio extremes, ignored upper gears
// and ties. Randomized phases follow: speed/rpm runs locked to one gear,
// floor violations and raw noise. Each result is checked against a scripted
// value or an in-bench estimator model, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_gear_ratio_matcher_hysteresis;
  import grm_pkg::*;

  localparam int NUM_GEARS   = 6;
  localparam int CYCLE_LIMIT = 1_500_000;

  typedef struct {
    logic [GEAR_W-1:0] gear;
    logic              ok;
    logic [TIME_W-1:0] stamp;
  } gear_est_t;

  typedef struct {
    bit                    is_cfg;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] data;
    logic [SPEED_W-1:0]    speed;
    logic [RPM_W-1:0]      rpm;
    logic [TIME_W-1:0]     now;
    bit                    typed;
    gear_est_t             want;
  } req_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  grm_in_if  in_ch ();
  grm_out_if out_ch ();

  gear_ratio_matcher_hysteresis #(.NUM_GEARS(NUM_GEARS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #10 clk = ~clk;

  // model copy of registers and state
  logic [CFG_DATA_W-1:0] ratio_lo    = RST_RATIO;
  logic [CFG_DATA_W-1:0] ratio_hi    = RST_RATIO;
  logic [SPEED_W-1:0]    floor_speed = RST_MIN_SPEED;
  logic [RPM_W-1:0]      floor_rpm   = RST_MIN_RPM;
  logic [ERR_W-1:0]      err_limit   = RST_THRESHOLD;
  logic [AGREE_W-1:0]    confirm_len = RST_HYST;
  logic [GEAR_W-1:0]     held_gear   = '0;
  logic                  held_ok     = 1'b0;
  logic [TIME_W-1:0]     held_stamp  = '0;
  logic [AGREE_W-1:0]    agree_run   = '0;
  logic [GEAR_W-1:0]     prev_winner = '0;

  gear_est_t         estimates_due[$];
  int                mismatches   = 0;
  int                results_seen = 0;
  int                cycle_count  = 0;
  bit                feed_gaps    = 1'b1;
  bit                drain_gaps   = 1'b1;
  logic [TIME_W-1:0] clock_us     = '0;
  req_row_t          script[$];

  function automatic logic [63:0] ratio_of(input int g);
    logic [63:0] word;
    word = (g <= 4) ? ratio_lo : ratio_hi;
    return (word >> (((g - 1) % 4) * RATIO_W)) & 64'hFFFF;
  endfunction

  function automatic gear_est_t estimate_gear(input logic [SPEED_W-1:0] speed,
                                              input logic [RPM_W-1:0] rpm,
                                              input logic [TIME_W-1:0] now);
    logic [63:0]       live, k, prod, diff, err, best_err;
    logic [GEAR_W-1:0] best;
    gear_est_t         res;
    if (speed == 0 || speed < floor_speed || rpm < floor_rpm) begin
      if (held_gear != 0) begin
        held_gear   = '0;
        held_ok     = 1'b0;
        held_stamp  = now;
        agree_run   = '0;
        prev_winner = '0;
      end
    end else begin
      live     = 64'(rpm) << LIVE_SHIFT;
      best_err = 64'(err_limit);
      best     = '0;
      for (int g = 1; g <= NUM_GEARS && g <= MAX_GEARS; g++) begin
        k = ratio_of(g);
        if (k != 0) begin
          prod = k * 64'(speed);
          diff = (live >= prod) ? live - prod : prod - live;
          err  = (diff << 16) / prod;
          if (err < best_err) begin
            best_err = err;
            best     = GEAR_W'(g);
          end
        end
      end
      if (best != 0 && best == prev_winner) begin
        if (agree_run != AGREE_MAX) agree_run = agree_run + 8'd1;
      end else begin
        agree_run   = 8'd1;
        prev_winner = best;
      end
      if (best != 0 && agree_run >= confirm_len) begin
        if (held_gear != best) begin
          held_gear  = best;
          held_ok    = 1'b1;
          held_stamp = now;
        end
      end else if (best == 0 && held_gear != 0) begin
        held_gear  = '0;
        held_ok    = 1'b0;
        held_stamp = now;
      end
    end
    res.gear  = held_gear;
    res.ok    = held_ok;
    res.stamp = held_stamp;
    return res;
  endfunction

  function automatic req_row_t reg_row(input cfg_idx_t idx, input logic [63:0] data);
    req_row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    r.speed  = '0;
    r.rpm    = '0;
    r.now    = '0;
    r.typed  = 1'b0;
    r.want   = '{default: '0};
    return r;
  endfunction

  function automatic req_row_t open_row(input logic [15:0] speed, input logic [14:0] rpm,
                                        input logic [63:0] now);
    req_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = CFG_RATIO_LO;
    r.data   = '0;
    r.speed  = speed;
    r.rpm    = rpm;
    r.now    = now;
    r.typed  = 1'b0;
    r.want   = '{default: '0};
    return r;
  endfunction

  function automatic req_row_t fixed_row(input logic [15:0] speed, input logic [14:0] rpm,
                                         input logic [63:0] now, input logic [3:0] gear,
                                         input logic ok, input logic [63:0] stamp);
    req_row_t r;
    r            = open_row(speed, rpm, now);
    r.typed      = 1'b1;
    r.want.gear  = gear;
    r.want.ok    = ok;
    r.want.stamp = stamp;
    return r;
  endfunction

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (estimates_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_RATIO_LO:  ratio_lo    = data;
      CFG_RATIO_HI:  ratio_hi    = data;
      CFG_MIN_SPEED: floor_speed = data[SPEED_W-1:0];
      CFG_MIN_RPM:   floor_rpm   = data[RPM_W-1:0];
      CFG_THRESHOLD: err_limit   = data[ERR_W-1:0];
      CFG_HYST:      confirm_len = data[AGREE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // one request: optional gap, offer, wait for the handshake, log the expectation
  task automatic send_sample(input req_row_t row);
    int        gap;
    gear_est_t est;
    gap = feed_gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.speed_raw  <= row.speed;
    in_ch.engine_rpm <= row.rpm;
    in_ch.now_us     <= row.now;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    est = estimate_gear(row.speed, row.rpm, row.now);
    estimates_due.push_back(row.typed ? row.want : est);
    @(negedge clk);
  endtask

  task automatic program_setting(input int style, input logic [15:0] spd_floor,
                                 input logic [14:0] rpm_floor, input logic [15:0] limit,
                                 input logic [7:0] confirm);
    logic [15:0] k [1:8];
    int          r;
    wait_results_drained();
    r = $urandom_range(90, 140);
    for (int g = 1; g <= 8; g++) begin
      if (style == 0) begin
        k[g] = 16'(r * 256 + $urandom_range(0, 255));
        r    = r * $urandom_range(60, 80) / 100;
        if ($urandom_range(0, 9) == 0) k[g] = '0;
      end else begin
        case ($urandom_range(0, 4))
          0: k[g] = '0;
          1: k[g] = '1;
          2: k[g] = (g > 1) ? k[g-1] : 16'($urandom);
          default: k[g] = 16'($urandom);
        endcase
      end
    end
    write_reg(CFG_RATIO_LO, {k[4], k[3], k[2], k[1]});
    write_reg(CFG_RATIO_HI, {k[8], k[7], k[6], k[5]});
    write_reg(CFG_MIN_SPEED, 64'(spd_floor));
    write_reg(CFG_MIN_RPM, 64'(rpm_floor));
    write_reg(CFG_THRESHOLD, 64'(limit));
    write_reg(CFG_HYST, 64'(confirm));
  endtask

  // runs of requests aimed at one gear, plus floor violations and raw noise
  task automatic run_phase(input int count, input bit long_runs);
    int          sent, run_len, mode, g, noise_div, delta;
    logic [63:0] k, base_speed, spd, est;
    req_row_t    row;
    sent       = 0;
    feed_gaps  = $urandom_range(0, 3) != 0;
    drain_gaps = $urandom_range(0, 3) != 0;
    noise_div  = long_runs ? 64 : 8;
    while (sent < count) begin
      run_len = long_runs ? $urandom_range(250, 300) : $urandom_range(1, 8);
      if (run_len > count - sent) run_len = count - sent;
      mode    = long_runs ? 0 : $urandom_range(0, 99);
      g       = long_runs ? $urandom_range(1, NUM_GEARS) : $urandom_range(1, 8);
      k       = ratio_of(g);
      if (k == 0) k = 64'($urandom_range(1, 65535));
      base_speed = (64'($urandom_range(600, 9000)) << LIVE_SHIFT) / k;
      if (base_speed == 0) base_speed = 1;
      if (base_speed > 65535) base_speed = 65535;
      repeat (run_len) begin
        row = open_row('0, '0, '0);
        if (mode < 70) begin
          spd = base_speed + $urandom_range(0, 3);
          if (spd > 65535) spd = 65535;
          est   = (k * spd) >> LIVE_SHIFT;
          delta = $urandom_range(0, int'(est / noise_div));
          est   = $urandom_range(0, 1) ? est + delta : est - delta;
          if (est > 32767) est = 32767;
          row.speed = spd[SPEED_W-1:0];
          row.rpm   = est[RPM_W-1:0];
        end else if (mode < 85) begin
          row.speed = 16'($urandom_range(0, 12000));
          row.rpm   = 15'($urandom_range(0, 32767));
          case ($urandom_range(0, 2))
            0: row.speed = '0;
            1: if (floor_speed != 0) row.speed = 16'($urandom_range(0, floor_speed - 1));
            default: if (floor_rpm != 0) row.rpm = 15'($urandom_range(0, floor_rpm - 1));
          endcase
        end else begin
          row.speed = 16'($urandom);
          row.rpm   = 15'($urandom);
        end
        if ($urandom_range(0, 15) == 0) clock_us = {$urandom, $urandom};
        else clock_us = clock_us + $urandom_range(1, 100000);
        row.now = clock_us;
        send_sample(row);
        sent++;
      end
    end
  endtask

  // result side
  initial begin
    int        hold;
    gear_est_t exp_est;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (results_seen == 150) hold = 600;  // long stall, input side backs up
      else hold = drain_gaps ? $urandom_range(0, 11) : 0;
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      results_seen++;
      if (estimates_due.size() == 0) begin
        $error("unexpected result: gear_out %0d gear_ok %0d change_time_us %0d",
               out_ch.gear_out, out_ch.gear_ok, out_ch.change_time_us);
        mismatches++;
      end else begin
        exp_est = estimates_due.pop_front();
        if (out_ch.gear_out !== exp_est.gear) begin
          $error("gear_out: expected %0d, got %0d", exp_est.gear, out_ch.gear_out);
          mismatches++;
        end
        if (out_ch.gear_ok !== exp_est.ok) begin
          $error("gear_ok: expected %0d, got %0d", exp_est.ok, out_ch.gear_ok);
          mismatches++;
        end
        if (out_ch.change_time_us !== exp_est.stamp) begin
          $error("change_time_us: expected %0d, got %0d", exp_est.stamp,
                 out_ch.change_time_us);
          mismatches++;
        end
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_gear_ratio_matcher_hysteresis: errors");
      $finish;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_RATIO_LO;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.speed_raw  <= '0;
    in_ch.engine_rpm <= '0;
    in_ch.now_us     <= '0;

    // gears 1..4: 120/70/48/36 rpm per km/h, gear 7 (ignored) is an exact 20
    script = {
      fixed_row(16'd0, 15'd0, 64'd0, 4'd0, 1'b0, 64'd0),
      fixed_row(16'hFFFF, 15'h7FFF, '1, 4'd0, 1'b0, 64'd0),
      reg_row(CFG_RATIO_LO, {16'd9216, 16'd12288, 16'd17920, 16'd30720}),
      reg_row(CFG_RATIO_HI, {16'd4096, 16'd5120, 16'd6144, 16'd7424}),
      reg_row(CFG_HYST, 64'd2),
      fixed_row(16'd6400, 15'd7000, 64'd100, 4'd0, 1'b0, 64'd0),
      fixed_row(16'd6400, 15'd7000, 64'd200, 4'd2, 1'b1, 64'd200),
      fixed_row(16'd6400, 15'd7000, 64'd300, 4'd2, 1'b1, 64'd200),
      fixed_row(16'd6400, 15'd2000, 64'd400, 4'd0, 1'b0, 64'd400),
      fixed_row(16'd6400, 15'd7000, 64'd500, 4'd0, 1'b0, 64'd400),
      fixed_row(16'd6400, 15'd7000, 64'd600, 4'd2, 1'b1, 64'd600),
      fixed_row(16'd100, 15'd7000, 64'd700, 4'd0, 1'b0, 64'd700),
      fixed_row(16'd0, 15'd7000, 64'd800, 4'd0, 1'b0, 64'd700),
      fixed_row(16'd6400, 15'd500, 64'd900, 4'd0, 1'b0, 64'd700),
      open_row(16'd6400, 15'd3000, 64'd1000),
      open_row(16'd6400, 15'd3000, 64'd1100),
      reg_row(CFG_HYST, 64'd0),
      fixed_row(16'd6400, 15'd12000, 64'd1200, 4'd1, 1'b1, 64'd1200),
      reg_row(CFG_THRESHOLD, 64'd0),
      fixed_row(16'd6400, 15'd12000, 64'd1300, 4'd0, 1'b0, 64'd1300),
      reg_row(CFG_THRESHOLD, 64'hFFFF),
      reg_row(CFG_HYST, 64'd1),
      open_row(16'd6400, 15'd7300, 64'd1400),
      reg_row(CFG_MIN_SPEED, 64'hFFFF),
      reg_row(CFG_MIN_RPM, 64'h7FFF),
      open_row(16'hFFFF, 15'h7FFF, 64'd1500),
      open_row(16'hFFFE, 15'h7FFF, 64'd1600),
      reg_row(CFG_MIN_SPEED, 64'd0),
      reg_row(CFG_MIN_RPM, 64'd0),
      open_row(16'd0, 15'h7FFF, 64'd1700),
      open_row(16'd1, 15'd0, 64'd1800),
      open_row(16'd1, 15'd1, '1),
      reg_row(CFG_RATIO_HI, {16'd4096, 16'd5120, 16'd7424, 16'd7424}),
      open_row(16'd6400, 15'd2900, 64'd1900)
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        wait_results_drained();
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_sample(script[i]);
      end
    end

    clock_us = 64'd10_000;
    program_setting(0, RST_MIN_SPEED, RST_MIN_RPM, RST_THRESHOLD, RST_HYST);
    run_phase(100, 1'b0);
    program_setting(0, 16'd320, 15'd800, 16'd13000, 8'd255);
    run_phase(280, 1'b1);
    program_setting(1, 16'd0, 15'd0, 16'hFFFF, 8'd0);
    run_phase(100, 1'b0);
    program_setting(0, 16'hFFFF, 15'h7FFF, 16'd0, 8'd1);
    run_phase(40, 1'b0);
    for (int p = 0; p < 6; p++) begin
      program_setting(p % 2, 16'($urandom_range(0, 1200)), 15'($urandom_range(0, 1500)),
                      16'($urandom_range(1500, 20000)), 8'($urandom_range(1, 6)));
      run_phase(80, 1'b0);
    end

    wait_results_drained();
    repeat (250) @(negedge clk);
    if (mismatches == 0 && estimates_due.size() == 0) begin
      $display("tb_gear_ratio_matcher_hysteresis: clean");
    end else begin
      $display("tb_gear_ratio_matcher_hysteresis: errors");
    end
    $finish;
  end

endmodule

// ----- gear_ratio_matcher_hysteresis.f -----
hw/rtl/grm_pkg.sv
hw/rtl/grm_if.sv
hw/rtl/grm_mul.sv
hw/rtl/grm_div.sv
hw/rtl/gear_ratio_matcher_hysteresis.sv
test/tb_gear_ratio_matcher_hysteresis.sv
